// ----- hw/rtl/dmcw_pkg.sv -----
// ----------------------------------------------------------------------------
// dmcw_pkg
// shared types, constants and register indexes of the dual motor command
// watchdog
// ----------------------------------------------------------------------------
package dmcw_pkg;

   // timer periods in millisecond ticks
   localparam int unsigned STATUS_PERIOD_MS = 5;
   localparam int unsigned ALIVE_PERIOD_MS  = 1000;
   localparam int unsigned BLINK_SLOW_MS    = 200;
   localparam int unsigned BLINK_FAST_MS    = 50;

   // default queue depths
   localparam int unsigned DEF_CMD_DEPTH = 2;
   localparam int unsigned DEF_RSP_DEPTH = 4;

   // full scale of a positive duty
   localparam int unsigned FWD_FULL_SCALE = 32767;

   // outgoing frame lengths
   localparam logic [2:0] TX_LEN_ERROR  = 3'd0;
   localparam logic [2:0] TX_LEN_ALIVE  = 3'd1;
   localparam logic [2:0] TX_LEN_STATUS = 3'd5;

   // expected lengths of received frames
   localparam logic [3:0] RX_LEN_REBOOT = 4'd0;
   localparam logic [3:0] RX_LEN_DRIVE  = 4'd4;
   localparam logic [3:0] RX_LEN_CLEAR  = 4'd0;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_RX_ID_REBOOT      = 3'd0,
      CSR_RX_ID_DRIVE       = 3'd1,
      CSR_RX_ID_CLEAR_ERROR = 3'd2,
      CSR_TX_ID_STATUS      = 3'd3,
      CSR_TX_ID_ERROR       = 3'd4,
      CSR_TX_ID_ALIVE       = 3'd5,
      CSR_PWM_TOP           = 3'd6,
      CSR_WATCHDOG_TICKS    = 3'd7
   } csr_index_type;

   // request classification
   typedef enum logic [2:0] {
      KIND_TICK,
      KIND_REBOOT,
      KIND_DRIVE,
      KIND_CLEAR,
      KIND_IGNORE
   } kind_type;

   // bridge input codes
   typedef enum logic [1:0] {
      DIR_COAST = 2'd0,
      DIR_FWD   = 2'd1,
      DIR_REV   = 2'd2
   } dir_type;

   typedef struct packed {
      logic [10:0] rx_id_reboot;
      logic [10:0] rx_id_drive;
      logic [10:0] rx_id_clear_error;
      logic [10:0] tx_id_status;
      logic [10:0] tx_id_error;
      logic [10:0] tx_id_alive;
      logic [15:0] pwm_top;
      logic [15:0] watchdog_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rx_id_reboot:      11'd0,
      rx_id_drive:       11'd1,
      rx_id_clear_error: 11'd2,
      tx_id_status:      11'd3,
      tx_id_error:       11'd4,
      tx_id_alive:       11'd5,
      pwm_top:           16'd3599,
      watchdog_ticks:    16'd10
   };

   typedef struct packed {
      logic        req_type;
      logic [10:0] rx_id;
      logic [3:0]  rx_len;
      logic [31:0] rx_payload;
      logic [13:0] angle_right;
      logic [13:0] angle_left;
   } req_item_type;

   typedef struct packed {
      logic        frame_valid;
      logic [10:0] tx_id;
      logic [2:0]  tx_len;
      logic [39:0] tx_payload;
      logic [15:0] compare_right;
      logic [15:0] compare_left;
      logic [1:0]  dir_right;
      logic [1:0]  dir_left;
      logic        drive_enable;
      logic        led_level;
      logic        reboot_request;
      logic        last;
   } rsp_item_type;

   // classified request handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [15:0] cmp_r;
      logic [15:0] cmp_l;
      dir_type     dir_r;
      dir_type     dir_l;
      logic [13:0] angle_r;
      logic [13:0] angle_l;
   } cmd_type;

   typedef struct packed {
      logic [10:0] tx_id;
      logic [2:0]  tx_len;
      logic [39:0] tx_payload;
   } frame_type;

   typedef struct packed {
      logic [15:0] cmp_r;
      logic [15:0] cmp_l;
      dir_type     dir_r;
      dir_type     dir_l;
      logic        enable;
   } drive_type;

endpackage

// ----- hw/rtl/dmcw_fifo.sv -----
// ----------------------------------------------------------------------------
// dmcw_fifo
// small first-in first-out queue of register entries
// ----------------------------------------------------------------------------
module dmcw_fifo #(
   parameter type         item_type = logic,
   parameter int unsigned DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type wdata,
   output logic     full,
   input  logic     pop,
   output item_type rdata,
   output logic     empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- hw/rtl/dmcw_front.sv -----
// ----------------------------------------------------------------------------
// dmcw_front
// accepts requests, classifies them and scales the two drive duties
// ----------------------------------------------------------------------------
module dmcw_front (
   input  logic                  clock,
   input  logic                  reset,
   input  dmcw_pkg::cfg_type     cfg,
   input  logic                  push,
   output logic                  full,
   input  dmcw_pkg::req_item_type req_data,
   output logic                  cmd_push,
   input  logic                  cmd_full,
   output dmcw_pkg::cmd_type     cmd_data
);

   logic                  a_valid_ff, a_valid_in;
   dmcw_pkg::kind_type    a_kind_ff;
   logic [31:0]           a_prod_r_ff, a_prod_l_ff;
   dmcw_pkg::dir_type     a_dir_r_ff, a_dir_l_ff;
   logic [13:0]           a_angle_r_ff, a_angle_l_ff;

   dmcw_pkg::kind_type    kind_in;
   logic [15:0]           raw_r, raw_l;
   logic [31:0]           prod_r_in, prod_l_in;
   logic                  load;

   // magnitude of a signed duty, the most negative one included
   function automatic logic [15:0] magnitude(input logic [15:0] raw);
      return raw[15] ? (~raw + 16'd1) : raw;
   endfunction

   function automatic dmcw_pkg::dir_type direction(input logic [15:0] raw);
      dmcw_pkg::dir_type d;
      if (raw == 16'd0) begin
         d = dmcw_pkg::DIR_COAST;
      end else if (raw[15]) begin
         d = dmcw_pkg::DIR_REV;
      end else begin
         d = dmcw_pkg::DIR_FWD;
      end
      return d;
   endfunction

   // divide by 32767: the remainder estimate stays below three divisors
   function automatic logic [15:0] div_fwd(input logic [31:0] x);
      logic [15:0] q0;
      logic [16:0] rem;
      logic [15:0] q;
      q0  = x[30:15];
      rem = {2'b00, x[14:0]} + {1'b0, q0};
      q   = q0 + 16'(rem >= 17'(dmcw_pkg::FWD_FULL_SCALE))
                 + 16'(rem >= 17'(2 * dmcw_pkg::FWD_FULL_SCALE));
      return q;
   endfunction

   assign full     = a_valid_ff && cmd_full;
   assign load     = push && !full;
   assign cmd_push = a_valid_ff && !cmd_full;

   // classify the request
   always_comb begin
      kind_in = dmcw_pkg::KIND_IGNORE;
      if (!req_data.req_type) begin
         kind_in = dmcw_pkg::KIND_TICK;
      end else if (req_data.rx_id == cfg.rx_id_reboot &&
                   req_data.rx_len == dmcw_pkg::RX_LEN_REBOOT) begin
         kind_in = dmcw_pkg::KIND_REBOOT;
      end else if (req_data.rx_id == cfg.rx_id_drive &&
                   req_data.rx_len == dmcw_pkg::RX_LEN_DRIVE) begin
         kind_in = dmcw_pkg::KIND_DRIVE;
      end else if (req_data.rx_id == cfg.rx_id_clear_error &&
                   req_data.rx_len == dmcw_pkg::RX_LEN_CLEAR) begin
         kind_in = dmcw_pkg::KIND_CLEAR;
      end
   end

   // one multiplier per channel
   assign raw_r     = req_data.rx_payload[31:16];
   assign raw_l     = req_data.rx_payload[15:0];
   assign prod_r_in = 32'(magnitude(raw_r)) * 32'(cfg.pwm_top);
   assign prod_l_in = 32'(magnitude(raw_l)) * 32'(cfg.pwm_top);

   always_comb begin
      a_valid_in = a_valid_ff;
      if (load) begin
         a_valid_in = 1'b1;
      end else if (cmd_push) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (load) begin
         a_kind_ff    <= kind_in;
         a_prod_r_ff  <= prod_r_in;
         a_prod_l_ff  <= prod_l_in;
         a_dir_r_ff   <= direction(raw_r);
         a_dir_l_ff   <= direction(raw_l);
         a_angle_r_ff <= req_data.angle_right;
         a_angle_l_ff <= req_data.angle_left;
      end
   end

   // final quotient: reverse divides by a power of two
   always_comb begin
      cmd_data.kind    = a_kind_ff;
      cmd_data.dir_r   = a_dir_r_ff;
      cmd_data.dir_l   = a_dir_l_ff;
      cmd_data.angle_r = a_angle_r_ff;
      cmd_data.angle_l = a_angle_l_ff;
      cmd_data.cmp_r   = (a_dir_r_ff == dmcw_pkg::DIR_REV) ? a_prod_r_ff[30:15]
                                                          : div_fwd(a_prod_r_ff);
      cmd_data.cmp_l   = (a_dir_l_ff == dmcw_pkg::DIR_REV) ? a_prod_l_ff[30:15]
                                                          : div_fwd(a_prod_l_ff);
   end

endmodule

// ----- hw/rtl/dmcw_back.sv -----
// ----------------------------------------------------------------------------
// dmcw_back
// error flag, timers, bridge state; unless stalled, emits a response per cycle
// ----------------------------------------------------------------------------
module dmcw_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dmcw_pkg::cfg_type      cfg,
   input  logic                   cmd_empty,
   output logic                   cmd_pop,
   input  dmcw_pkg::cmd_type      cmd_data,
   input  logic                   out_full,
   output logic                   out_push,
   output dmcw_pkg::rsp_item_type out_data
);

   // block state
   logic                  error_ff, error_in;
   logic [15:0]           wd_count_ff, wd_count_in;
   logic                  wd_armed_ff, wd_armed_in;
   logic [7:0]            st_count_ff, st_count_in;
   logic                  st_running_ff, st_running_in;
   logic [9:0]            al_count_ff, al_count_in;
   logic                  first_alive_ff, first_alive_in;
   logic [7:0]            bl_count_ff, bl_count_in;
   logic                  bl_fast_ff, bl_fast_in;
   logic                  led_ff, led_in;
   dmcw_pkg::drive_type   drive_ff, drive_in;

   // responses of the request in hand
   dmcw_pkg::frame_type   slot_ff [3];
   dmcw_pkg::frame_type   slot_in [3];
   logic [1:0]            nres_ff, nres_in;
   logic [1:0]            idx_ff, idx_in;
   logic                  has_frame_ff, has_frame_in;
   logic                  reboot_ff, reboot_in;
   logic                  active_ff, active_in;

   logic                  last_res, last_push;
   logic                  restarted;
   logic [1:0]            nfr;
   logic [8:0]            bl_sum;
   logic [7:0]            bl_period;
   logic [16:0]           wd_sum;
   logic [8:0]            st_sum;
   logic [10:0]           al_sum;
   logic [39:0]           st_payload;

   assign last_res  = (idx_ff == nres_ff - 2'd1);
   assign out_push  = active_ff && !out_full;
   assign last_push = out_push && last_res;
   assign cmd_pop   = !cmd_empty && (!active_ff || last_push);

   assign st_payload = {8'(error_in), 2'b00, cmd_data.angle_r, 2'b00, cmd_data.angle_l};

   // next state for the request at the head of the queue
   always_comb begin
      error_in       = error_ff;
      wd_count_in    = wd_count_ff;
      wd_armed_in    = wd_armed_ff;
      st_count_in    = st_count_ff;
      st_running_in  = st_running_ff;
      al_count_in    = al_count_ff;
      first_alive_in = first_alive_ff;
      bl_count_in    = bl_count_ff;
      bl_fast_in     = bl_fast_ff;
      led_in         = led_ff;
      drive_in       = drive_ff;
      reboot_in      = 1'b0;
      restarted      = 1'b0;
      nfr            = 2'd0;
      slot_in[0]     = '0;
      slot_in[1]     = '0;
      slot_in[2]     = '0;
      bl_period      = bl_fast_ff ? 8'(dmcw_pkg::BLINK_FAST_MS) : 8'(dmcw_pkg::BLINK_SLOW_MS);
      bl_sum         = {1'b0, bl_count_ff} + 9'd1;
      wd_sum         = {1'b0, wd_count_ff} + 17'd1;
      st_sum         = {1'b0, st_count_ff} + 9'd1;
      al_sum         = {1'b0, al_count_ff} + 11'd1;

      case (cmd_data.kind)
         dmcw_pkg::KIND_TICK: begin
            // led blink timer
            if (bl_sum >= {1'b0, bl_period}) begin
               bl_count_in = '0;
               led_in      = !led_ff;
            end else begin
               bl_count_in = bl_sum[7:0];
            end
            // command watchdog
            if (wd_armed_ff) begin
               if (wd_sum >= {1'b0, cfg.watchdog_ticks}) begin
                  wd_armed_in   = 1'b0;
                  wd_count_in   = '0;
                  error_in      = 1'b1;
                  drive_in      = '0;
                  bl_fast_in    = 1'b0;
                  bl_count_in   = '0;
                  st_running_in = 1'b1;
                  st_count_in   = '0;
                  restarted     = 1'b1;
                  slot_in[nfr]  = '{tx_id: cfg.tx_id_error,
                                    tx_len: dmcw_pkg::TX_LEN_ERROR,
                                    tx_payload: 40'd0};
                  nfr           = nfr + 2'd1;
               end else begin
                  wd_count_in = wd_sum[15:0];
               end
            end
            // periodic status
            if (st_running_ff && !restarted) begin
               if (st_sum >= 9'(dmcw_pkg::STATUS_PERIOD_MS)) begin
                  st_count_in  = '0;
                  slot_in[nfr] = '{tx_id: cfg.tx_id_status,
                                   tx_len: dmcw_pkg::TX_LEN_STATUS,
                                   tx_payload: st_payload};
                  nfr          = nfr + 2'd1;
               end else begin
                  st_count_in = st_sum[7:0];
               end
            end
            // alive frame
            if (al_sum >= 11'(dmcw_pkg::ALIVE_PERIOD_MS)) begin
               al_count_in    = '0;
               slot_in[nfr]   = '{tx_id: cfg.tx_id_alive,
                                  tx_len: dmcw_pkg::TX_LEN_ALIVE,
                                  tx_payload: {7'd0, first_alive_ff, 32'd0}};
               nfr            = nfr + 2'd1;
               first_alive_in = 1'b0;
            end else begin
               al_count_in = al_sum[9:0];
            end
         end
         dmcw_pkg::KIND_REBOOT: begin
            reboot_in = 1'b1;
         end
         dmcw_pkg::KIND_DRIVE: begin
            if (!error_ff) begin
               drive_in.cmp_r = cmd_data.cmp_r;
               drive_in.cmp_l = cmd_data.cmp_l;
               drive_in.dir_r = cmd_data.dir_r;
               drive_in.dir_l = cmd_data.dir_l;
               slot_in[0]     = '{tx_id: cfg.tx_id_status,
                                  tx_len: dmcw_pkg::TX_LEN_STATUS,
                                  tx_payload: st_payload};
               nfr            = 2'd1;
               wd_armed_in    = 1'b1;
               wd_count_in    = '0;
            end
         end
         dmcw_pkg::KIND_CLEAR: begin
            error_in        = 1'b0;
            drive_in.enable = 1'b1;
            st_running_in   = 1'b0;
            st_count_in     = '0;
            wd_armed_in     = 1'b1;
            wd_count_in     = '0;
            bl_fast_in      = 1'b1;
            bl_count_in     = '0;
         end
         default: begin
         end
      endcase

      has_frame_in = (nfr != 2'd0);
      nres_in      = has_frame_in ? nfr : 2'd1;
   end

   // response sequencing
   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      if (cmd_pop) begin
         active_in = 1'b1;
         idx_in    = '0;
      end else if (last_push) begin
         active_in = 1'b0;
      end else if (out_push) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_ff       <= 1'b1;
         wd_count_ff    <= '0;
         wd_armed_ff    <= 1'b1;
         st_count_ff    <= '0;
         st_running_ff  <= 1'b1;
         al_count_ff    <= '0;
         first_alive_ff <= 1'b1;
         bl_count_ff    <= '0;
         bl_fast_ff     <= 1'b0;
         led_ff         <= 1'b0;
         drive_ff       <= '0;
         active_ff      <= 1'b0;
         idx_ff         <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         if (cmd_pop) begin
            error_ff       <= error_in;
            wd_count_ff    <= wd_count_in;
            wd_armed_ff    <= wd_armed_in;
            st_count_ff    <= st_count_in;
            st_running_ff  <= st_running_in;
            al_count_ff    <= al_count_in;
            first_alive_ff <= first_alive_in;
            bl_count_ff    <= bl_count_in;
            bl_fast_ff     <= bl_fast_in;
            led_ff         <= led_in;
            drive_ff       <= drive_in;
         end
      end
   end

   // response payload of the request in hand
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         slot_ff[0]   <= slot_in[0];
         slot_ff[1]   <= slot_in[1];
         slot_ff[2]   <= slot_in[2];
         nres_ff      <= nres_in;
         has_frame_ff <= has_frame_in;
         reboot_ff    <= reboot_in;
      end
   end

   // response assembly
   always_comb begin
      out_data.frame_valid    = has_frame_ff;
      out_data.tx_id          = slot_ff[idx_ff].tx_id;
      out_data.tx_len         = slot_ff[idx_ff].tx_len;
      out_data.tx_payload     = slot_ff[idx_ff].tx_payload;
      out_data.compare_right  = drive_ff.cmp_r;
      out_data.compare_left   = drive_ff.cmp_l;
      out_data.dir_right      = drive_ff.dir_r;
      out_data.dir_left       = drive_ff.dir_l;
      out_data.drive_enable   = drive_ff.enable;
      out_data.led_level      = led_ff;
      out_data.reboot_request = reboot_ff;
      out_data.last           = last_res;
   end

endmodule

// ----- hw/rtl/dual_motor_command_watchdog.sv -----
// ----------------------------------------------------------------------------
// dual_motor_command_watchdog
// command watchdog, status timers and two h-bridge drive states
// ----------------------------------------------------------------------------
// A request is a millisecond tick or a received bus frame. The front stage
// accepts one request per cycle unless a full command queue holds it back,
// passes it through duty multiply, product register and quotient, and hands
// it to a short command queue; the back stage updates the watchdog, timers
// and bridge state and emits one response per cycle through its single
// response port while the output queue has room, one or two responses per
// request (error or status, then alive frames on a tick). It takes the next
// request as it emits the last response of the one in hand. Responses wait
// in an output queue, and drive, LED and reboot fields show the state after
// the whole request. Configuration must be written only while no request is
// in flight; the block itself does not enforce this.
module dual_motor_command_watchdog #(
   parameter int unsigned CMD_DEPTH = dmcw_pkg::DEF_CMD_DEPTH,
   parameter int unsigned RSP_DEPTH = dmcw_pkg::DEF_RSP_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  dmcw_pkg::req_item_type req_data,
   output logic                   empty,
   input  logic                   pop,
   output dmcw_pkg::rsp_item_type rsp_data,
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_wdata
);

   dmcw_pkg::cfg_type      cfg_ff, cfg_in;
   logic                   cmd_push, cmd_full, cmd_pop, cmd_empty;
   dmcw_pkg::cmd_type      cmd_wdata, cmd_rdata;
   logic                   rsp_push, rsp_full;
   dmcw_pkg::rsp_item_type rsp_wdata;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            dmcw_pkg::CSR_RX_ID_REBOOT:      cfg_in.rx_id_reboot      = csr_wdata[10:0];
            dmcw_pkg::CSR_RX_ID_DRIVE:       cfg_in.rx_id_drive       = csr_wdata[10:0];
            dmcw_pkg::CSR_RX_ID_CLEAR_ERROR: cfg_in.rx_id_clear_error = csr_wdata[10:0];
            dmcw_pkg::CSR_TX_ID_STATUS:      cfg_in.tx_id_status      = csr_wdata[10:0];
            dmcw_pkg::CSR_TX_ID_ERROR:       cfg_in.tx_id_error       = csr_wdata[10:0];
            dmcw_pkg::CSR_TX_ID_ALIVE:       cfg_in.tx_id_alive       = csr_wdata[10:0];
            dmcw_pkg::CSR_PWM_TOP:           cfg_in.pwm_top           = csr_wdata;
            dmcw_pkg::CSR_WATCHDOG_TICKS:    cfg_in.watchdog_ticks    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= dmcw_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request decode and duty scaling
   dmcw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_data (cmd_wdata)
   );

   // command queue between front and back
   dmcw_fifo #(
      .item_type (dmcw_pkg::cmd_type),
      .DEPTH     (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   // state update and response generation
   dmcw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_rdata),
      .out_full  (rsp_full),
      .out_push  (rsp_push),
      .out_data  (rsp_wdata)
   );

   // response queue
   dmcw_fifo #(
      .item_type (dmcw_pkg::rsp_item_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_data),
      .empty (empty)
   );

`ifndef NO_ASSERTIONS
   // front never writes into a full command queue
   a_cmd_no_overflow : assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command queue written while full");

   // back never writes into a full response queue
   a_rsp_no_overflow : assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("response queue written while full");

   // a response without a frame is always the only one of its request
   a_no_frame_is_last : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.frame_valid) |-> rsp_data.last)
      else $error("frameless response not marked last");

   // disabled bridges always coast with zero compares
   a_disabled_coasts : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.drive_enable) |->
         (rsp_data.dir_right == dmcw_pkg::DIR_COAST &&
          rsp_data.dir_left == dmcw_pkg::DIR_COAST &&
          rsp_data.compare_right == 16'd0 && rsp_data.compare_left == 16'd0))
      else $error("bridge driven while disabled");
`endif

endmodule
